@@ rtl/fct_pkg.sv @@
// ----------------------------------------------------------------------------
// fct_pkg - shared types and constants of the flow counter table
// Key, event and result words, status codes and state machine states.
// ----------------------------------------------------------------------------
package fct_pkg;

  localparam int FLOW_ENTRIES = 256;
  localparam int IDX_W        = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
  localparam int CNT_W        = $clog2(FLOW_ENTRIES + 1);
  localparam int KEY_W        = 128;
  localparam int CTR_W        = 164;
  localparam int QDEPTH       = 2;

  typedef enum logic [1:0] {
    ST_UPDATED  = 2'd0,
    ST_INSERTED = 2'd1,
    ST_DROPPED  = 2'd2,
    ST_SKIPPED  = 2'd3
  } status_t;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] proc_id;
    logic        is_tx;
    logic [31:0] byte_count;
    logic        retransmit_flag;
    logic [3:0]  sock_state;
  } event_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  entry_index;
    logic [63:0] rx_total;
    logic [63:0] tx_total;
    logic [31:0] retransmit_total;
    logic [3:0]  conn_state;
  } result_t;

  // queue word: event plus front-end classification
  typedef struct packed {
    event_t ev;
    logic   skip;
  } job_t;

  typedef struct packed {
    logic [63:0] rx;
    logic [63:0] tx;
    logic [31:0] retr;
    logic [3:0]  st;
  } ctr_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_CMP,
    BK_CREAD,
    BK_CWAIT,
    BK_OUT
  } bk_state_t;

endpackage

@@ rtl/fct_if.sv @@
// ----------------------------------------------------------------------------
// fct_in_if / fct_out_if - valid/ready channels of the flow counter table
// One interface per channel with source and sink modports.
// ----------------------------------------------------------------------------
interface fct_in_if;
  logic            valid;
  logic            ready;
  fct_pkg::event_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface fct_out_if;
  logic             valid;
  logic             ready;
  fct_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/fct_ram.sv @@
// ----------------------------------------------------------------------------
// fct_ram - generic single-port RAM
// One address per cycle: read always, write when we; registered read data.
// ----------------------------------------------------------------------------
module fct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

@@ rtl/fct_front.sv @@
// ----------------------------------------------------------------------------
// fct_front - event intake and queue
// Flags zero-address events and buffers words for the back end.
// ----------------------------------------------------------------------------
module fct_front (
  input  logic           clk,
  input  logic           rst_n,
  fct_in_if.sink         in_ch,
  output logic           q_valid,
  output fct_pkg::job_t  q_data,
  input  logic           q_pop
);
  localparam int PW = $clog2(fct_pkg::QDEPTH);

  fct_pkg::job_t       buf_r [fct_pkg::QDEPTH];
  logic [PW-1:0]       wp_r, rp_r;
  logic [PW:0]         cnt_r;
  logic                push;
  fct_pkg::job_t       job;

  assign in_ch.ready = (cnt_r != (PW+1)'(fct_pkg::QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != '0);
  assign q_data      = buf_r[rp_r];

  always_comb begin
    job.ev   = in_ch.data;
    job.skip = (in_ch.data.src_addr == '0) || (in_ch.data.dst_addr == '0);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r] <= job;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (q_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(q_pop);
    end
  end
endmodule

@@ rtl/fct_back.sv @@
// ----------------------------------------------------------------------------
// fct_back - table search and counter update
// Scans used slots in turn, then inserts, updates or drops; emits a result.
// ----------------------------------------------------------------------------
module fct_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  fct_pkg::job_t  q_data,
  output logic           q_pop,
  fct_out_if.source      out_ch
);
  localparam int IW = fct_pkg::IDX_W;
  localparam int CW = fct_pkg::CNT_W;

  fct_pkg::bk_state_t state_r, state_nxt;
  fct_pkg::job_t      job_r;
  logic [IW-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]      used_r, used_nxt;
  logic               ins_r, ins_nxt;
  fct_pkg::result_t   res_r, res_nxt;
  logic               ov_r, ov_nxt;
  logic               load;

  logic                       key_we, ctr_we;
  logic [IW-1:0]              addr;
  logic [fct_pkg::KEY_W-1:0]  key_rd, key_wr;
  fct_pkg::ctr_t              ctr_rd, ctr_wr;
  logic [fct_pkg::CTR_W-1:0]  ctr_rd_raw;
  logic [63:0]                add_b;

  assign key_wr = {job_r.ev.src_addr, job_r.ev.dst_addr, job_r.ev.src_port,
                   job_r.ev.dst_port, job_r.ev.proc_id};
  assign ctr_rd = ctr_rd_raw;
  assign add_b  = {32'd0, job_r.ev.byte_count};
  assign addr   = idx_r;

  fct_ram #(.WIDTH(fct_pkg::KEY_W), .DEPTH(fct_pkg::FLOW_ENTRIES)) u_key (
    .clk(clk), .we(key_we), .addr(addr), .wdata(key_wr), .rdata(key_rd));

  fct_ram #(.WIDTH(fct_pkg::CTR_W), .DEPTH(fct_pkg::FLOW_ENTRIES)) u_ctr (
    .clk(clk), .we(ctr_we), .addr(addr), .wdata(ctr_wr), .rdata(ctr_rd_raw));

  assign out_ch.valid = ov_r;
  assign out_ch.data  = res_r;

  always_comb begin
    fct_pkg::ctr_t base;
    base          = ins_r ? '0 : ctr_rd;
    ctr_wr        = base;
    if (job_r.ev.is_tx) ctr_wr.tx = base.tx + add_b;
    else                ctr_wr.rx = base.rx + add_b;
    ctr_wr.retr   = base.retr + 32'(job_r.ev.retransmit_flag);
    ctr_wr.st     = job_r.ev.sock_state;

    state_nxt = state_r;
    idx_nxt   = idx_r;
    used_nxt  = used_r;
    ins_nxt   = ins_r;
    res_nxt   = res_r;
    ov_nxt    = ov_r && !out_ch.ready;
    q_pop     = 1'b0;
    load      = 1'b0;
    key_we    = 1'b0;
    ctr_we    = 1'b0;

    unique case (state_r)
      fct_pkg::BK_IDLE: begin
        // result register must be free before the next word is taken
        if (q_valid && !ov_r) begin
          q_pop   = 1'b1;
          load    = 1'b1;
          idx_nxt = '0;
          ins_nxt = 1'b0;
          if (q_data.skip) begin
            res_nxt        = '0;
            res_nxt.status = fct_pkg::ST_SKIPPED;
            state_nxt      = fct_pkg::BK_OUT;
          end else if (used_r == '0) begin
            ins_nxt   = 1'b1;
            state_nxt = fct_pkg::BK_CREAD;
          end else begin
            state_nxt = fct_pkg::BK_READ;
          end
        end
      end
      fct_pkg::BK_READ: state_nxt = fct_pkg::BK_CMP;
      fct_pkg::BK_CMP: begin
        if (key_rd == key_wr) begin
          state_nxt = fct_pkg::BK_CREAD;
        end else if ((CW)'(idx_r) + 1'b1 == used_r) begin
          if (used_r == (CW)'(fct_pkg::FLOW_ENTRIES)) begin
            res_nxt        = '0;
            res_nxt.status = fct_pkg::ST_DROPPED;
            state_nxt      = fct_pkg::BK_OUT;
          end else begin
            idx_nxt   = used_r[IW-1:0];
            ins_nxt   = 1'b1;
            state_nxt = fct_pkg::BK_CREAD;
          end
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = fct_pkg::BK_READ;
        end
      end
      fct_pkg::BK_CREAD: state_nxt = fct_pkg::BK_CWAIT;
      fct_pkg::BK_CWAIT: begin
        ctr_we = 1'b1;
        key_we = ins_r;
        if (ins_r) used_nxt = used_r + 1'b1;
        res_nxt.status           = ins_r ? fct_pkg::ST_INSERTED : fct_pkg::ST_UPDATED;
        res_nxt.entry_index      = 8'(idx_r);
        res_nxt.rx_total         = ctr_wr.rx;
        res_nxt.tx_total         = ctr_wr.tx;
        res_nxt.retransmit_total = ctr_wr.retr;
        res_nxt.conn_state       = ctr_wr.st;
        state_nxt                = fct_pkg::BK_OUT;
      end
      fct_pkg::BK_OUT: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt    = 1'b1;
          state_nxt = fct_pkg::BK_IDLE;
        end
      end
      default: state_nxt = fct_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) job_r <= q_data;
    idx_r <= idx_nxt;
    ins_r <= ins_nxt;
    res_r <= res_nxt;
    if (!rst_n) begin
      state_r <= fct_pkg::BK_IDLE;
      used_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      ov_r    <= ov_nxt;
    end
  end
endmodule

@@ rtl/flow_counter_table.sv @@
// ----------------------------------------------------------------------------
// flow_counter_table - per-flow statistics table
// Looks up or inserts a flow per event and returns its updated totals.
// ----------------------------------------------------------------------------
// channel  dir  word
// in_      in   event_t  (key, byte count, flags, state)
// out_     out  result_t (status, slot, totals)
//
// A skipped event goes straight to output; otherwise used slots are read and
// compared in turn through the single-port key RAM, then counters are updated.
// Reset clears the slot count, not the RAMs; slots past it are never searched.
// A 2-word queue takes events while the back end works or the output stalls.
// ----------------------------------------------------------------------------
module flow_counter_table (
  input logic        clk,
  input logic        rst_n,
  fct_in_if.sink     in_ch,
  fct_out_if.source  out_ch
);
  logic          q_valid, q_pop;
  fct_pkg::job_t q_data;

  fct_front u_front (.clk(clk), .rst_n(rst_n), .in_ch(in_ch),
                     .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop));

  fct_back u_back (.clk(clk), .rst_n(rst_n), .q_valid(q_valid),
                   .q_data(q_data), .q_pop(q_pop), .out_ch(out_ch));

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.data.status == fct_pkg::ST_DROPPED) |->
      (u_back.used_r == fct_pkg::CNT_W'(fct_pkg::FLOW_ENTRIES)))
    else $error("drop with free slots");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> $stable(out_ch.data))
    else $error("result changed while stalled");
endmodule
